### hdl/sseg_pkg.sv
// Shared constants, command codes and divider interface types for the envelope generator.
package sseg_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int SCALE_W = 24;
    localparam int ALPHA_W = 17;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Phase is a Q0.16 fraction; the divider produces this many quotient bits
    localparam int QBITS = 16;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Smoothstep factor 3*ONE - 2*p fits the width of 3*ONE, two bits above QBITS
    localparam int K_W = QBITS + 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << QBITS;
    localparam logic [K_W-1:0]     SMOOTH_K  = K_W'(3) << QBITS;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REPORT  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EASE_OUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd2;

    // Divider request: num must be below den, den nonzero
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    // Divider response: done pulses for one cycle with the quotient
    typedef struct packed {
        logic             done;
        logic [QBITS-1:0] quot;
    } div_rsp_t;

endpackage

### hdl/sseg_div.sv
// Restoring divider, one quotient bit per cycle, for floor(num * 2^16 / den).
module sseg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sseg_pkg::div_req_t req,
    output sseg_pkg::div_rsp_t rsp
);
    import sseg_pkg::*;

    localparam int CNT_W = $clog2(QBITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [QBITS-1:0]  quo_reg;

    // One shift, compare and subtract step
    logic [TIME_W:0] rem_shift;
    logic            fits;
    logic [TIME_W:0] rem_sub;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= req.num;
                den_reg  <= req.den;
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
                quo_reg <= {quo_reg[QBITS-2:0], fits};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

### hdl/smoothstep_envelope_generator_unit.sv
// Smoothstep envelope generator: sequencer around a shared multiplier and a serial divider.
// Words go one at a time through the 16-step divider and shared multiplier (up to four uses
// per word). Evaluation skips both when inactive, uses the multiplier once on the plateau,
// and adds a divide and two products while easing; a restart ease-out remap adds a divide
// and a multiply (no divide when past the end). A new word is taken while a result waits.
// Reset (rst_n, asynchronous, active low) clears all state, registers and the result.
module smoothstep_envelope_generator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input words
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sseg_pkg::CMD_W-1:0]       cmd,
    input  logic [sseg_pkg::TIME_W-1:0]      delta_time,
    input  logic [sseg_pkg::SCALE_W-1:0]     shake_scale,
    input  logic                             child_present,
    input  logic signed [sseg_pkg::TIME_W-1:0] child_time_left,
    // Result words
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sseg_pkg::ALPHA_W-1:0]     alpha,
    output logic [sseg_pkg::SCALE_W-1:0]     scale_out,
    output logic [sseg_pkg::TIME_W-1:0]      time_left,
    output logic                             active,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sseg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sseg_pkg::TIME_W-1:0]      cfg_data
);
    import sseg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_RDIV,
        S_RMUL,
        S_RWB,
        S_EVAL,
        S_PDIV,
        S_PMUL1,
        S_PMUL2,
        S_PMUL3,
        S_SMUL,
        S_SOUT,
        S_DONE
    } state_t;

    // Configuration registers
    logic [TIME_W-1:0] cfg_ein_reg, cfg_eout_reg, cfg_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ein_reg   <= '0;
            cfg_eout_reg  <= '0;
            cfg_total_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EASE_IN:  cfg_ein_reg   <= cfg_data;
                CFG_EASE_OUT: cfg_eout_reg  <= cfg_data;
                CFG_TOTAL:    cfg_total_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [TIME_W-1:0]   dt_reg, dt_next;
    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic                child_reg, child_next;
    logic [TIME_W-1:0]   craw_reg, craw_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   run_total_reg, run_total_next;
    logic [TIME_W-1:0]   ein_reg, ein_next;
    logic [TIME_W-1:0]   eout_reg, eout_next;
    logic [QBITS-1:0]    quot_reg, quot_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ALPHA_W-1:0]  alpha_reg, alpha_next;
    logic [SCALE_W-1:0]  sres_reg, sres_next;
    logic [TIME_W-1:0]   left_reg, left_next;
    logic                act_reg, act_next;
    logic                div_start_reg, div_start_next;
    logic [TIME_W-1:0]   div_num_reg, div_num_next;
    logic [TIME_W-1:0]   div_den_reg, div_den_next;
    logic                out_valid_reg, out_valid_next;
    logic [ALPHA_W-1:0]  alpha_out_reg, alpha_out_next;
    logic [SCALE_W-1:0]  scale_out_reg, scale_out_next;
    logic [TIME_W-1:0]   left_out_reg, left_out_next;
    logic                act_out_reg, act_out_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign div_req.start = div_start_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = div_den_reg;

    sseg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Envelope phase tests
    logic easing_in, easing_out;
    assign easing_in  = (ein_reg != '0) && (elapsed_reg < ein_reg);
    assign easing_out = (eout_reg != '0) &&
                        (({1'b0, elapsed_reg} + {1'b0, eout_reg}) > {1'b0, run_total_reg});

    // Saturating time updates
    logic [TIME_W:0]   frame_sum, ext_sum, ease_sum;
    logic [TIME_W+1:0] dbl_diff;
    logic [TIME_W-1:0] frame_sat, ext_sat, dbl_sat;

    assign frame_sum = {1'b0, elapsed_reg} + {1'b0, dt_reg};
    assign frame_sat = frame_sum[TIME_W] ? TIME_MAX : frame_sum[TIME_W-1:0];
    assign ext_sum   = {1'b0, run_total_reg} + {1'b0, elapsed_reg};
    assign ext_sat   = ext_sum[TIME_W] ? TIME_MAX : ext_sum[TIME_W-1:0];
    assign dbl_diff  = {1'b0, run_total_reg, 1'b0} - {2'b00, elapsed_reg};
    assign ease_sum  = {1'b0, cfg_ein_reg} + {1'b0, cfg_eout_reg};

    always_comb
    begin
        priority if (dbl_diff[TIME_W+1])
            dbl_sat = '0;
        else if (dbl_diff[TIME_W])
            dbl_sat = TIME_MAX;
        else
            dbl_sat = dbl_diff[TIME_W-1:0];
    end

    // Envelope time left and child clamp
    logic [TIME_W-1:0] env_left, left_clamp;
    assign env_left   = run_total_reg - elapsed_reg;
    assign left_clamp = (craw_reg[TIME_W-1] || (craw_reg >= env_left)) ? env_left : craw_reg;

    // Shared multiplier operand select
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [K_W-1:0]     smooth_k;

    assign smooth_k = SMOOTH_K - {1'b0, quot_reg, 1'b0};

    always_comb
    begin
        unique case (state_reg)
            S_RMUL:
            begin
                mul_a = ein_reg;
                mul_b = {{(MUL_B_W-QBITS){1'b0}}, quot_reg};
            end
            S_PMUL1:
            begin
                mul_a = {{(MUL_A_W-QBITS){1'b0}}, quot_reg};
                mul_b = {{(MUL_B_W-QBITS){1'b0}}, quot_reg};
            end
            S_PMUL2:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = {{(MUL_B_W-K_W){1'b0}}, smooth_k};
            end
            S_SMUL:
            begin
                mul_a = {{(MUL_A_W-ALPHA_W){1'b0}}, alpha_reg};
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dt_next        = dt_reg;
        scale_next     = scale_reg;
        child_next     = child_reg;
        craw_next      = craw_reg;
        elapsed_next   = elapsed_reg;
        run_total_next = run_total_reg;
        ein_next       = ein_reg;
        eout_next      = eout_reg;
        quot_next      = quot_reg;
        alpha_next     = alpha_reg;
        sres_next      = sres_reg;
        left_next      = left_reg;
        act_next       = act_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        out_valid_next = out_valid_reg && !out_ready;
        alpha_out_next = alpha_out_reg;
        scale_out_next = scale_out_reg;
        left_out_next  = left_out_reg;
        act_out_next   = act_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    dt_next    = delta_time;
                    scale_next = shake_scale;
                    child_next = child_present;
                    craw_next  = child_time_left;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_EVAL;
                unique case (cmd_reg)
                    CMD_START:
                    begin
                        run_total_next = cfg_total_reg;
                        elapsed_next   = '0;
                        if (ease_sum > {1'b0, cfg_total_reg})
                        begin
                            ein_next  = cfg_total_reg >> 1;
                            eout_next = cfg_total_reg >> 1;
                        end
                        else
                        begin
                            ein_next  = cfg_ein_reg;
                            eout_next = cfg_eout_reg;
                        end
                    end
                    CMD_FRAME:
                    begin
                        if (elapsed_reg < run_total_reg)
                            elapsed_next = frame_sat;
                    end
                    CMD_RESTART:
                    begin
                        priority if (easing_in)
                            run_total_next = ext_sat;
                        else if (easing_out)
                        begin
                            // remap ease-out progress onto the ease-in ramp
                            if (run_total_reg > elapsed_reg)
                            begin
                                div_start_next = 1'b1;
                                div_num_next   = env_left;
                                div_den_next   = eout_reg;
                                state_next     = S_RDIV;
                            end
                            else
                            begin
                                quot_next  = '0;
                                state_next = S_RMUL;
                            end
                        end
                        else
                            run_total_next = dbl_sat;
                    end
                    CMD_REPORT: ;
                    default: ;
                endcase
            end
            S_RDIV:
            begin
                if (div_rsp.done)
                begin
                    quot_next  = div_rsp.quot;
                    state_next = S_RMUL;
                end
            end
            S_RMUL:
                state_next = S_RWB;
            S_RWB:
            begin
                elapsed_next = prod_reg[QBITS+TIME_W-1:QBITS];
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                if ((elapsed_reg >= run_total_reg) || !child_reg)
                begin
                    alpha_next = '0;
                    sres_next  = '0;
                    left_next  = '0;
                    act_next   = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    left_next = left_clamp;
                    act_next  = 1'b1;
                    priority if (easing_in)
                    begin
                        div_start_next = 1'b1;
                        div_num_next   = elapsed_reg;
                        div_den_next   = ein_reg;
                        state_next     = S_PDIV;
                    end
                    else if (easing_out)
                    begin
                        div_start_next = 1'b1;
                        div_num_next   = env_left;
                        div_den_next   = eout_reg;
                        state_next     = S_PDIV;
                    end
                    else
                    begin
                        alpha_next = ALPHA_ONE;
                        state_next = S_SMUL;
                    end
                end
            end
            S_PDIV:
            begin
                if (div_rsp.done)
                begin
                    quot_next  = div_rsp.quot;
                    state_next = S_PMUL1;
                end
            end
            S_PMUL1:
                state_next = S_PMUL2;
            S_PMUL2:
                state_next = S_PMUL3;
            S_PMUL3:
            begin
                // p*p*(3 - 2p) scaled down by 2^32
                alpha_next = prod_reg[2*QBITS+ALPHA_W-1:2*QBITS];
                state_next = S_SMUL;
            end
            S_SMUL:
                state_next = S_SOUT;
            S_SOUT:
            begin
                sres_next  = prod_reg[QBITS+SCALE_W-1:QBITS];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // load the output register once the previous word has left
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    alpha_out_next = alpha_reg;
                    scale_out_next = sres_reg;
                    left_out_next  = left_reg;
                    act_out_next   = act_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            dt_reg        <= '0;
            scale_reg     <= '0;
            child_reg     <= 1'b0;
            craw_reg      <= '0;
            elapsed_reg   <= '0;
            run_total_reg <= '0;
            ein_reg       <= '0;
            eout_reg      <= '0;
            quot_reg      <= '0;
            prod_reg      <= '0;
            alpha_reg     <= '0;
            sres_reg      <= '0;
            left_reg      <= '0;
            act_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            div_num_reg   <= '0;
            div_den_reg   <= '0;
            out_valid_reg <= 1'b0;
            alpha_out_reg <= '0;
            scale_out_reg <= '0;
            left_out_reg  <= '0;
            act_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            dt_reg        <= dt_next;
            scale_reg     <= scale_next;
            child_reg     <= child_next;
            craw_reg      <= craw_next;
            elapsed_reg   <= elapsed_next;
            run_total_reg <= run_total_next;
            ein_reg       <= ein_next;
            eout_reg      <= eout_next;
            quot_reg      <= quot_next;
            prod_reg      <= prod_next;
            alpha_reg     <= alpha_next;
            sres_reg      <= sres_next;
            left_reg      <= left_next;
            act_reg       <= act_next;
            div_start_reg <= div_start_next;
            div_num_reg   <= div_num_next;
            div_den_reg   <= div_den_next;
            out_valid_reg <= out_valid_next;
            alpha_out_reg <= alpha_out_next;
            scale_out_reg <= scale_out_next;
            left_out_reg  <= left_out_next;
            act_out_reg   <= act_out_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign alpha     = alpha_out_reg;
    assign scale_out = scale_out_reg;
    assign time_left = left_out_reg;
    assign active    = act_out_reg;

endmodule

### hdl/sseg_checker.sv
// Port-level checks for the envelope generator, bound to the top level.
module sseg_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [sseg_pkg::ALPHA_W-1:0]       alpha,
    input logic [sseg_pkg::SCALE_W-1:0]       scale_out,
    input logic [sseg_pkg::TIME_W-1:0]        time_left,
    input logic                               active,
    input logic                               cfg_ready
);
    import sseg_pkg::*;

    // An accepted word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous word still in work");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alpha) && $stable(scale_out) &&
                                    $stable(time_left) && $stable(active))
        else $error("stalled result changed");

    // An inactive result carries all-zero fields
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> alpha == '0 && scale_out == '0 && time_left == '0)
        else $error("inactive result has nonzero fields");

    // Gain never exceeds unity
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha <= ALPHA_ONE)
        else $error("alpha above unity");

    // Configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind smoothstep_envelope_generator_unit sseg_checker u_sseg_checker (.*);
